// ===== rtl/core/two_plane_tile_row_renderer_assert.svh =====
// assertion macros for the tile row renderer
// used by the top level and the pixel emitter, no other dependencies
`ifndef TWO_PLANE_TILE_ROW_RENDERER_ASSERT_SVH
`define TWO_PLANE_TILE_ROW_RENDERER_ASSERT_SVH

// condition must never hold outside reset
`define TPRR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define TPRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tprr_pkg.sv =====
// shared types, codes and constants of the tile row renderer
// no dependencies
package tprr_pkg;

  // request codes
  localparam logic [1:0] REQ_TILE_CODE = 2'd0;
  localparam logic [1:0] REQ_ATTRIBUTE = 2'd1;
  localparam logic [1:0] REQ_PATTERN   = 2'd2;
  localparam logic [1:0] REQ_RENDER    = 2'd3;

  // default sizes
  localparam int CELL_STORE_DEPTH_DEF = 256;
  localparam int PATTERN_DEPTH_DEF    = 65536;
  localparam int PALETTE_ENTRIES_DEF  = 32;

  // fixed field widths
  localparam int TILE_ADDR_W = 15;
  localparam int STORE_ADDR_W = 16;
  localparam int PEN_W = 5;
  localparam int RGB_W = 24;
  localparam int PEN_COUNT = 32;
  localparam logic [2:0] PIXEL_LAST = 3'd7;

  // fixed colour table, red in the high byte
  localparam logic [RGB_W-1:0] COLOUR_INIT [PEN_COUNT] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'haa0000,
    24'h000000, 24'hffffff, 24'hffaa00, 24'haa5500,
    24'h000000, 24'hffffff, 24'hff0000, 24'hffaa00,
    24'h000000, 24'hffaa00, 24'hff0000, 24'hff5500,
    24'h000000, 24'hffff00, 24'hffaa00, 24'haa5500,
    24'h000000, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h000000, 24'h0000ff, 24'haaff00, 24'hffaa00,
    24'h000000, 24'hff00ff, 24'haa00aa, 24'h550055
  };

  // one fetched cell handed from the fetch side to the pixel emitter
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] line;
    logic [2:0] grp;
    logic [7:0] plane0;
    logic [7:0] plane1;
  } tile_beat_t;

endpackage

// ===== rtl/core/tprr_ram.sv =====
// generic single write port ram with registered read and read enable
// depends on tprr_pkg for default sizes
module tprr_ram
  import tprr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CELL_STORE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-edge write is seen by later reads only
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/tprr_emitter.sv =====
// pixel emitter: turns one fetched cell into eight pixel beats, one per clock
// depends on tprr_pkg and the assertion macro header
`include "two_plane_tile_row_renderer_assert.svh"
module tprr_emitter
  import tprr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tile_beat_t       beat,
  output logic             take,
  output logic             strobe,
  output logic [10:0]      pixel_x,
  output logic [7:0]       pixel_line,
  output logic [PEN_W-1:0] pen_index,
  output logic [RGB_W-1:0] pixel_rgb,
  output logic             last_pixel
);

  logic       active;
  logic [2:0] k;
  logic [7:0] col;
  logic [7:0] line;
  logic [2:0] grp;
  logic [7:0] p0sh;
  logic [7:0] p1sh;
  logic [RGB_W-1:0] rgb_lut [PEN_COUNT];

  // colour lookup, pen wrapped to the palette size at elaboration
  for (genvar g = 0; g < PEN_COUNT; g++) begin : g_rgb
    assign rgb_lut[g] = COLOUR_INIT[g % PALETTE_ENTRIES];
  end

  // free for a new cell when idle or on the last pixel
  assign take = !active || (k == PIXEL_LAST);

  // pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= 3'd0;
    end else if (load) begin
      active <= 1'b1;
      k      <= 3'd0;
    end else if (active) begin
      k <= k + 3'd1;
      if (k == PIXEL_LAST) begin
        active <= 1'b0;
      end
    end
  end

  // plane shifters, leftmost pixel in bit 7
  always_ff @(posedge clk) begin
    if (load) begin
      col  <= beat.col;
      line <= beat.line;
      grp  <= beat.grp;
      p0sh <= beat.plane0;
      p1sh <= beat.plane1;
    end else if (active) begin
      p0sh <= {p0sh[6:0], 1'b0};
      p1sh <= {p1sh[6:0], 1'b0};
    end
  end

  // result beat
  assign strobe     = active;
  assign pixel_x    = {col, k};
  assign pixel_line = line;
  assign pen_index  = {grp, p1sh[7], p0sh[7]};
  assign pixel_rgb  = rgb_lut[pen_index];
  assign last_pixel = active && (k == PIXEL_LAST);

  `TPRR_ASSERT_NEVER(a_load_when_full, clk, rst, load && !take, "cell loaded while emitter busy")
  `TPRR_ASSERT_NEXT(a_pixel_run, clk, rst, strobe && !last_pixel, strobe && (pixel_x == $past(pixel_x) + 11'd1), "pixel run broken")
  `TPRR_ASSERT_NEXT(a_gap_after_last, clk, rst, last_pixel && !load, !strobe, "beat after last pixel without new cell")

endmodule

// ===== rtl/core/two_plane_tile_row_renderer.sv =====
// top level of the two-plane tile row renderer: cell fetch sequencer and stores
// depends on tprr_pkg, tprr_ram, tprr_emitter and the assertion macro header
//
// A write item (tile code, attribute or pattern byte) is taken whenever busy is
// low. A render item reads the cell stores at the accept edge, then the pattern
// store twice over its single read port in states S_A0 and S_A1, and in S_P1
// hands both plane bytes to the pixel emitter. The emitter sends one pixel beat
// per clock on strobe, eight per cell, left to right, and the receiver cannot
// stall it. While the emitter works on one cell the next render is fetched, so
// the render rate is set by the emitter's one pixel per clock. busy stays high
// from a render accept until its planes are handed over, which waits for the
// emitter's last pixel when it is still busy. Stores need no clearing after reset.
`include "two_plane_tile_row_renderer_assert.svh"
module two_plane_tile_row_renderer
  import tprr_pkg::*;
#(
  parameter int CELL_STORE_DEPTH = CELL_STORE_DEPTH_DEF,
  parameter int PATTERN_DEPTH    = PATTERN_DEPTH_DEF,
  parameter int PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type,
  input  logic [STORE_ADDR_W-1:0] store_address,
  input  logic [7:0]              store_data,
  input  logic [13:0]             row_start,
  input  logic [3:0]              raster_row,
  input  logic [7:0]              cell_column,
  input  logic [7:0]              screen_line,
  output logic                    strobe,
  output logic [10:0]             pixel_x,
  output logic [7:0]              pixel_line,
  output logic [PEN_W-1:0]        pen_index,
  output logic [RGB_W-1:0]        pixel_rgb,
  output logic                    last_pixel
);

  localparam int CAW = $clog2(CELL_STORE_DEPTH);
  localparam int PAW = $clog2(PATTERN_DEPTH);
  localparam int MW  = STORE_ADDR_W + 5;

  // fetch sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CELL = 3'd1;
  localparam logic [2:0] S_A0   = 3'd2;
  localparam logic [2:0] S_A1   = 3'd3;
  localparam logic [2:0] S_P1   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       render_acc;
  logic       take;
  logic       handoff;

  logic [7:0]             f_col;
  logic [3:0]             f_row;
  logic [7:0]             f_line;
  logic [TILE_ADDR_W-1:0] taddr;
  logic [2:0]             grp;
  logic [7:0]             p0;

  logic                    wr_pend;
  logic [STORE_ADDR_W-1:0] wr_addr;
  logic [7:0]              wr_data;

  logic [CAW-1:0] cell_lut [256];
  logic [7:0]     cell_sum;
  logic [7:0]     tile_rdata;
  logic [7:0]     attr_rdata;
  logic [STORE_ADDR_W-1:0] mod_in;
  logic [PAW-1:0] mod_out;
  logic           pat_re;
  logic [7:0]     pat_rdata;
  tile_beat_t     beat;

  // wrap of a pattern address into the store, four compare and subtract steps
  function automatic logic [PAW-1:0] pat_wrap(input logic [STORE_ADDR_W-1:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    for (int s = 3; s >= 0; s--) begin
      if (r >= (MW'(PATTERN_DEPTH) << s)) begin
        r = r - (MW'(PATTERN_DEPTH) << s);
      end
    end
    return PAW'(r);
  endfunction

  // cell store index wrap table
  for (genvar g = 0; g < 256; g++) begin : g_cell
    assign cell_lut[g] = CAW'(g % CELL_STORE_DEPTH);
  end

  // handshake
  assign handoff    = (state == S_P1) && take;
  assign busy       = (state != S_IDLE) && !handoff;
  assign accept     = start && !busy;
  assign render_acc = accept && (req_type == REQ_RENDER);
  assign cell_sum   = row_start[8:1] + {1'b0, cell_column[7:1]};

  // cell stores, written at accept and read at render accept
  tprr_ram #(.WIDTH(8), .DEPTH(CELL_STORE_DEPTH)) u_tile_ram (
    .clk   (clk),
    .we    (accept && (req_type == REQ_TILE_CODE)),
    .waddr (cell_lut[store_address[7:0]]),
    .wdata (store_data),
    .re    (render_acc),
    .raddr (cell_lut[cell_sum]),
    .rdata (tile_rdata)
  );

  tprr_ram #(.WIDTH(8), .DEPTH(CELL_STORE_DEPTH)) u_attr_ram (
    .clk   (clk),
    .we    (accept && (req_type == REQ_ATTRIBUTE)),
    .waddr (cell_lut[store_address[7:0]]),
    .wdata (store_data),
    .re    (render_acc),
    .raddr (cell_lut[cell_sum]),
    .rdata (attr_rdata)
  );

  // shared address wrap: pending write, else plane 0 or plane 1 fetch
  always_comb begin
    if (wr_pend) begin
      mod_in = wr_addr;
    end else if (state == S_A1) begin
      mod_in = {1'b1, taddr};
    end else begin
      mod_in = {1'b0, taddr};
    end
  end

  assign mod_out = pat_wrap(mod_in);
  assign pat_re  = (state == S_A0) || (state == S_A1);

  // pattern store, written in the cycle after the write beat
  tprr_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (mod_out),
    .wdata (wr_data),
    .re    (pat_re),
    .raddr (mod_out),
    .rdata (pat_rdata)
  );

  // pattern write staging
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= accept && (req_type == REQ_PATTERN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr <= store_address;
      wr_data <= store_data;
    end
  end

  // fetch sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (render_acc) state_next = S_CELL;
      end
      S_CELL: state_next = S_A0;
      S_A0:   state_next = S_A1;
      S_A1:   state_next = S_P1;
      S_P1: begin
        if (handoff) state_next = render_acc ? S_CELL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fetch payload: item fields, tile address, palette group, plane 0 byte
  always_ff @(posedge clk) begin
    if (render_acc) begin
      f_col  <= cell_column;
      f_row  <= raster_row;
      f_line <= screen_line;
    end
    if (state == S_CELL) begin
      taddr <= {f_col[0], attr_rdata[1:0], tile_rdata, f_row};
      grp   <= attr_rdata[6:4];
    end
    if (state == S_A1) begin
      p0 <= pat_rdata;
    end
  end

  // hand the fetched cell to the emitter
  always_comb begin
    beat.col    = f_col;
    beat.line   = f_line;
    beat.grp    = grp;
    beat.plane0 = p0;
    beat.plane1 = pat_rdata;
  end

  tprr_emitter #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (handoff),
    .beat       (beat),
    .take       (take),
    .strobe     (strobe),
    .pixel_x    (pixel_x),
    .pixel_line (pixel_line),
    .pen_index  (pen_index),
    .pixel_rgb  (pixel_rgb),
    .last_pixel (last_pixel)
  );

  `TPRR_ASSERT_NEVER(a_wrap_shared, clk, rst, wr_pend && ((state == S_A0) || (state == S_A1)), "pattern write collides with plane fetch")
  `TPRR_ASSERT_NEXT(a_render_starts, clk, rst, render_acc, state == S_CELL, "render accept did not start fetch")
  `TPRR_ASSERT_NEXT(a_plane1_held, clk, rst, (state == S_P1) && !take, (state == S_P1) && $stable(pat_rdata) && $stable(p0), "waiting planes lost")

endmodule
